[hdl/tsab_pkg.sv]
`timescale 1ns / 1ps

package tsab_pkg;

   // Field widths.
   localparam int ENERGY_W = 40;
   localparam int BETA_W   = 32;
   localparam int WEIGHT_W = 32;
   localparam int ALPHA_W  = 36;

   // Control and status register port.
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 40;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TEMPERATURE_ENERGY = 1'b0,
      CSR_WEIGHT_RATIO       = 1'b1
   } csr_index_type;

   localparam logic [ENERGY_W-1:0] TEMPERATURE_RESET = 40'd27818;
   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET      = 32'd65536;

   // Arithmetic sizes.
   localparam int RADICAND_W = 56;
   localparam int ROOT_IN_W  = 62;
   localparam int ROOT_W     = ROOT_IN_W / 2;
   localparam int DEN_W      = ENERGY_W + WEIGHT_W;
   localparam int ALPHA_NUM_W = 90;
   localparam int BETA_NUM_W  = ENERGY_W + 16;
   localparam int QUO_W      = ALPHA_W;

   // Pipeline depth, from request accept to the response strobe.
   localparam int SQRT_STAGES = ROOT_W;
   localparam int DIV_STAGES  = QUO_W + 1;
   localparam int LATENCY     = 4 + SQRT_STAGES + 2 + DIV_STAGES + 1;

   // Saturation values.
   localparam logic [ALPHA_W-1:0] ALPHA_SAT    = '1;
   localparam logic [BETA_W-1:0]  BETA_MIN_SAT = 32'h8000_0000;

endpackage

[hdl/thermal_scatter_alpha_beta_limits_top.sv]
`timescale 1ns / 1ps

// Kinematic limits for S(alpha,beta) thermal scattering. Each request gives
// an energy E and a transfer beta; for each request one response returns
// beta_min = -E/kT and alpha_min/alpha_max = (sqrt(E) -/+ sqrt(E+beta*kT))^2
// / (A*kT), with flags for beta below beta_min and for clipped values. The
// block takes a new request every cycle; busy is high only in reset. The
// latency is set by the two square roots (31 stages, one bit each) and the
// dividers (37 stages). The response strobe is high for one cycle and cannot
// be held off, so the receiver must take every response. Write kT and A only
// while no request is in flight; they take effect for the next request.
module thermal_scatter_alpha_beta_limits_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [tsab_pkg::ENERGY_W-1:0]          req_energy,
   input  logic signed [tsab_pkg::BETA_W-1:0]     req_beta,
   output logic                                   rsp_strobe,
   output logic signed [tsab_pkg::BETA_W-1:0]     rsp_beta_min,
   output logic [tsab_pkg::ALPHA_W-1:0]           rsp_alpha_min,
   output logic [tsab_pkg::ALPHA_W-1:0]           rsp_alpha_max,
   output logic                                   rsp_beta_invalid,
   output logic                                   rsp_saturated,
   input  logic                                   csr_write,
   input  logic [tsab_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [tsab_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   localparam int EW = tsab_pkg::ENERGY_W;
   localparam int BW = tsab_pkg::BETA_W;
   localparam int WW = tsab_pkg::WEIGHT_W;
   localparam int AW = tsab_pkg::ALPHA_W;
   localparam int RW = tsab_pkg::RADICAND_W;
   localparam int QW = tsab_pkg::ROOT_W;
   localparam int DW = tsab_pkg::DEN_W;
   localparam int NW = tsab_pkg::ALPHA_NUM_W;
   localparam int TAG_W = EW + 1;

   // Configuration registers and the derived alpha divisor.
   logic [EW-1:0]    temperature_ff;
   logic [WW-1:0]    weight_ff;
   logic [EW+15:0]   den_hi_ff;
   logic [WW+15:0]   den_lo_ff;
   logic [DW-1:0]    den_ff;

   // Front stages.
   logic             s1_valid_ff;
   logic [EW-1:0]    s1_energy_ff;
   logic             s1_neg_ff;
   logic [BW-1:0]    s1_bmag_ff;
   logic [BW-1:0]    s1_bmag_in;

   logic             s2_valid_ff;
   logic [EW-1:0]    s2_energy_ff;
   logic             s2_neg_ff;
   logic [RW-1:0]    s2_phi_ff;
   logic [BW+15:0]   s2_plo_ff;

   logic             s3_valid_ff;
   logic [EW-1:0]    s3_energy_ff;
   logic             s3_neg_ff;
   logic [RW-1:0]    s3_p_ff;
   logic             s3_rem_nz_ff;
   logic [DW-1:0]    s3_prod_in;

   logic             s4_valid_ff;
   logic [EW-1:0]    s4_energy_ff;
   logic [RW-1:0]    s4_rad_ff;
   logic             s4_invalid_ff;
   logic [RW-1:0]    s4_rad_in;
   logic             s4_invalid_in;
   logic [RW-1:0]    s4_e_ext;

   // Root unit outputs.
   logic             sq_valid;
   logic [QW-1:0]    sq_se;
   logic [QW-1:0]    sq_sr;
   logic [TAG_W-1:0] sq_tag;

   // Numerator stages.
   logic             s5_valid_ff;
   logic [EW-1:0]    s5_energy_ff;
   logic             s5_invalid_ff;
   logic [QW-1:0]    s5_diff_ff;
   logic [QW:0]      s5_sum_ff;

   logic             s6_valid_ff;
   logic [EW-1:0]    s6_energy_ff;
   logic             s6_invalid_ff;
   logic [2*QW-1:0]  s6_nmin_ff;
   logic [2*QW+1:0]  s6_nmax_ff;

   // Divider outputs and the flag that travels beside them.
   logic             bdiv_valid;
   logic [tsab_pkg::QUO_W-1:0] bdiv_quo;
   logic             bdiv_ovf;
   logic             amin_valid;
   logic [tsab_pkg::QUO_W-1:0] amin_quo;
   logic             amin_ovf;
   logic             amax_valid;
   logic [tsab_pkg::QUO_W-1:0] amax_quo;
   logic             amax_ovf;
   logic             inv_pipe_ff [tsab_pkg::DIV_STAGES];

   // Response register.
   logic             rsp_strobe_ff;
   logic [BW-1:0]    rsp_beta_min_ff;
   logic [AW-1:0]    rsp_alpha_min_ff;
   logic [AW-1:0]    rsp_alpha_max_ff;
   logic             rsp_beta_invalid_ff;
   logic             rsp_saturated_ff;
   logic [BW-1:0]    rsp_beta_min_in;
   logic [AW-1:0]    rsp_alpha_min_in;
   logic [AW-1:0]    rsp_alpha_max_in;
   logic             rsp_saturated_in;
   logic             temp_zero;
   logic             weight_zero;
   logic             beta_sat;

   assign busy = reset;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         temperature_ff <= tsab_pkg::TEMPERATURE_RESET;
         weight_ff      <= tsab_pkg::WEIGHT_RESET;
      end else if (csr_write) begin
         case (tsab_pkg::csr_index_type'(csr_index))
            tsab_pkg::CSR_TEMPERATURE_ENERGY: temperature_ff <= csr_wdata[EW-1:0];
            tsab_pkg::CSR_WEIGHT_RATIO:       weight_ff      <= csr_wdata[WW-1:0];
            default: ;
         endcase
      end
   end

   // A times kT, in two partial products and a sum.
   always_ff @(posedge clock) begin
      den_hi_ff <= (EW+16)'(weight_ff) * (EW+16)'(temperature_ff[EW-1:16]);
      den_lo_ff <= (WW+16)'(weight_ff) * (WW+16)'(temperature_ff[15:0]);
      den_ff    <= {den_hi_ff, 16'd0} + DW'(den_lo_ff);
   end

   // Stage 1: capture the request and take the magnitude of beta.
   assign s1_bmag_in = req_beta[BW-1] ? BW'(-req_beta) : BW'(req_beta);

   // Stage 3: whole product beta*kT, split into integer part and fraction.
   assign s3_prod_in = {s2_phi_ff, 16'd0} + DW'(s2_plo_ff);

   // Stage 4: radicand E + beta*kT, rounded down and clamped at zero.
   assign s4_e_ext = RW'(s3_energy_ff);
   always_comb begin
      s4_invalid_in = 1'b0;
      if (!s3_neg_ff) begin
         s4_rad_in = s4_e_ext + s3_p_ff;
      end else if (s4_e_ext < s3_p_ff || (s4_e_ext == s3_p_ff && s3_rem_nz_ff)) begin
         s4_rad_in     = '0;
         s4_invalid_in = 1'b1;
      end else begin
         s4_rad_in = s4_e_ext - s3_p_ff - RW'(s3_rem_nz_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
      s1_energy_ff  <= req_energy;
      s1_neg_ff     <= req_beta[BW-1];
      s1_bmag_ff    <= s1_bmag_in;
      s2_energy_ff  <= s1_energy_ff;
      s2_neg_ff     <= s1_neg_ff;
      s2_phi_ff     <= RW'(s1_bmag_ff) * RW'(temperature_ff[EW-1:16]);
      s2_plo_ff     <= (BW+16)'(s1_bmag_ff) * (BW+16)'(temperature_ff[15:0]);
      s3_energy_ff  <= s2_energy_ff;
      s3_neg_ff     <= s2_neg_ff;
      s3_p_ff       <= s3_prod_in[DW-1:16];
      s3_rem_nz_ff  <= s3_prod_in[15:0] != 16'd0;
      s4_energy_ff  <= s3_energy_ff;
      s4_rad_ff     <= s4_rad_in;
      s4_invalid_ff <= s4_invalid_in;
   end

   // Roots of E and of the radicand, both first scaled by 2^6.
   tsab_sqrt_pipe #(
      .IN_W  (tsab_pkg::ROOT_IN_W),
      .TAG_W (TAG_W)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s4_valid_ff),
      .in_a      ({16'd0, s4_energy_ff, 6'd0}),
      .in_b      ({s4_rad_ff, 6'd0}),
      .in_tag    ({s4_invalid_ff, s4_energy_ff}),
      .out_valid (sq_valid),
      .out_a     (sq_se),
      .out_b     (sq_sr),
      .out_tag   (sq_tag)
   );

   // Stages 5 and 6: difference and sum of the roots, then their squares.
   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
      end else begin
         s5_valid_ff <= sq_valid;
         s6_valid_ff <= s5_valid_ff;
      end
      s5_energy_ff  <= sq_tag[EW-1:0];
      s5_invalid_ff <= sq_tag[EW];
      s5_diff_ff    <= (sq_se > sq_sr) ? (sq_se - sq_sr) : (sq_sr - sq_se);
      s5_sum_ff     <= (QW+1)'(sq_se) + (QW+1)'(sq_sr);
      s6_energy_ff  <= s5_energy_ff;
      s6_invalid_ff <= s5_invalid_ff;
      s6_nmin_ff    <= (2*QW)'(s5_diff_ff) * (2*QW)'(s5_diff_ff);
      s6_nmax_ff    <= (2*QW+2)'(s5_sum_ff) * (2*QW+2)'(s5_sum_ff);
   end

   // E * 2^16 / kT.
   tsab_div_pipe #(
      .NUM_W (tsab_pkg::BETA_NUM_W),
      .DEN_W (EW),
      .QUO_W (tsab_pkg::QUO_W)
   ) u_beta_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s6_valid_ff),
      .in_num    ({s6_energy_ff, 16'd0}),
      .in_den    (temperature_ff),
      .out_valid (bdiv_valid),
      .out_quo   (bdiv_quo),
      .out_ovf   (bdiv_ovf)
   );

   // Numerators times 2^26 over A*kT.
   tsab_div_pipe #(
      .NUM_W (NW),
      .DEN_W (DW),
      .QUO_W (tsab_pkg::QUO_W)
   ) u_amin_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s6_valid_ff),
      .in_num    ({2'd0, s6_nmin_ff, 26'd0}),
      .in_den    (den_ff),
      .out_valid (amin_valid),
      .out_quo   (amin_quo),
      .out_ovf   (amin_ovf)
   );

   tsab_div_pipe #(
      .NUM_W (NW),
      .DEN_W (DW),
      .QUO_W (tsab_pkg::QUO_W)
   ) u_amax_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s6_valid_ff),
      .in_num    ({s6_nmax_ff, 26'd0}),
      .in_den    (den_ff),
      .out_valid (amax_valid),
      .out_quo   (amax_quo),
      .out_ovf   (amax_ovf)
   );

   // The beta flag waits beside the dividers.
   always_ff @(posedge clock) begin
      inv_pipe_ff[0] <= s6_invalid_ff;
      for (int i = 1; i < tsab_pkg::DIV_STAGES; i++) begin
         inv_pipe_ff[i] <= inv_pipe_ff[i-1];
      end
   end

   // Saturation and the zero-configuration cases.
   assign temp_zero   = temperature_ff == '0;
   assign weight_zero = weight_ff == '0;
   assign beta_sat    = bdiv_ovf || bdiv_quo[tsab_pkg::QUO_W-1:BW] != '0
                        || (bdiv_quo[BW-1] && bdiv_quo[BW-2:0] != '0);

   always_comb begin
      rsp_saturated_in = 1'b0;
      if (temp_zero || beta_sat) begin
         rsp_beta_min_in  = tsab_pkg::BETA_MIN_SAT;
         rsp_saturated_in = 1'b1;
      end else begin
         rsp_beta_min_in = BW'(0) - bdiv_quo[BW-1:0];
      end
      if (temp_zero || weight_zero) begin
         rsp_alpha_min_in = tsab_pkg::ALPHA_SAT;
         rsp_alpha_max_in = tsab_pkg::ALPHA_SAT;
         rsp_saturated_in = 1'b1;
      end else begin
         rsp_alpha_min_in = amin_ovf ? tsab_pkg::ALPHA_SAT : amin_quo;
         rsp_alpha_max_in = amax_ovf ? tsab_pkg::ALPHA_SAT : amax_quo;
         if (amin_ovf || amax_ovf) begin
            rsp_saturated_in = 1'b1;
         end
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= bdiv_valid && amin_valid && amax_valid;
      end
      rsp_beta_min_ff     <= rsp_beta_min_in;
      rsp_alpha_min_ff    <= rsp_alpha_min_in;
      rsp_alpha_max_ff    <= rsp_alpha_max_in;
      rsp_beta_invalid_ff <= inv_pipe_ff[tsab_pkg::DIV_STAGES-1];
      rsp_saturated_ff    <= rsp_saturated_in;
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_beta_min     = rsp_beta_min_ff;
   assign rsp_alpha_min    = rsp_alpha_min_ff;
   assign rsp_alpha_max    = rsp_alpha_max_ff;
   assign rsp_beta_invalid = rsp_beta_invalid_ff;
   assign rsp_saturated    = rsp_saturated_ff;

endmodule

[hdl/tsab_sqrt_pipe.sv]
`timescale 1ns / 1ps

// Two integer square roots side by side, one result bit per stage.
module tsab_sqrt_pipe #(
   parameter int IN_W  = 62,
   parameter int TAG_W = 41
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [IN_W-1:0]       in_a,
   input  logic [IN_W-1:0]       in_b,
   input  logic [TAG_W-1:0]      in_tag,
   output logic                  out_valid,
   output logic [IN_W/2-1:0]     out_a,
   output logic [IN_W/2-1:0]     out_b,
   output logic [TAG_W-1:0]      out_tag
);

   localparam int ROOT_W = IN_W / 2;
   localparam int REM_W  = ROOT_W + 3;

   typedef struct packed {
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } step_type;

   logic              valid_ff  [ROOT_W];
   logic [IN_W-1:0]   rad_a_ff  [ROOT_W];
   logic [IN_W-1:0]   rad_b_ff  [ROOT_W];
   logic [REM_W-1:0]  rem_a_ff  [ROOT_W];
   logic [REM_W-1:0]  rem_b_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_a_ff [ROOT_W];
   logic [ROOT_W-1:0] root_b_ff [ROOT_W];
   logic [TAG_W-1:0]  tag_ff    [ROOT_W];

   // One digit of the restoring square root: bring down two radicand bits and
   // try to subtract four times the root plus one.
   function automatic step_type root_step(input logic [REM_W-1:0]  rem,
                                          input logic [ROOT_W-1:0] root,
                                          input logic [1:0]        pair);
      logic [REM_W-1:0] shifted;
      logic [REM_W-1:0] trial;
      step_type         res;
      shifted = {rem[REM_W-3:0], pair};
      trial   = {{(REM_W-ROOT_W-2){1'b0}}, root, 2'b01};
      if (shifted >= trial) begin
         res.rem  = shifted - trial;
         res.root = {root[ROOT_W-2:0], 1'b1};
      end else begin
         res.rem  = shifted;
         res.root = {root[ROOT_W-2:0], 1'b0};
      end
      return res;
   endfunction

   for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
      localparam int PAIR_LO = IN_W - 2 - 2 * s;

      logic              v_src;
      logic [IN_W-1:0]   a_src;
      logic [IN_W-1:0]   b_src;
      logic [REM_W-1:0]  ra_src;
      logic [REM_W-1:0]  rb_src;
      logic [ROOT_W-1:0] qa_src;
      logic [ROOT_W-1:0] qb_src;
      logic [TAG_W-1:0]  t_src;
      step_type          step_a;
      step_type          step_b;

      // The first stage starts from the ports with an empty remainder.
      if (s == 0) begin : g_head
         assign v_src  = in_valid;
         assign a_src  = in_a;
         assign b_src  = in_b;
         assign ra_src = '0;
         assign rb_src = '0;
         assign qa_src = '0;
         assign qb_src = '0;
         assign t_src  = in_tag;
      end else begin : g_body
         assign v_src  = valid_ff[s-1];
         assign a_src  = rad_a_ff[s-1];
         assign b_src  = rad_b_ff[s-1];
         assign ra_src = rem_a_ff[s-1];
         assign rb_src = rem_b_ff[s-1];
         assign qa_src = root_a_ff[s-1];
         assign qb_src = root_b_ff[s-1];
         assign t_src  = tag_ff[s-1];
      end

      assign step_a = root_step(ra_src, qa_src, a_src[PAIR_LO +: 2]);
      assign step_b = root_step(rb_src, qb_src, b_src[PAIR_LO +: 2]);

      // Stage register.
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= v_src;
         end
         rad_a_ff[s]  <= a_src;
         rad_b_ff[s]  <= b_src;
         rem_a_ff[s]  <= step_a.rem;
         rem_b_ff[s]  <= step_b.rem;
         root_a_ff[s] <= step_a.root;
         root_b_ff[s] <= step_b.root;
         tag_ff[s]    <= t_src;
      end
   end

   assign out_valid = valid_ff[ROOT_W-1];
   assign out_a     = root_a_ff[ROOT_W-1];
   assign out_b     = root_b_ff[ROOT_W-1];
   assign out_tag   = tag_ff[ROOT_W-1];

endmodule

[hdl/tsab_div_pipe.sv]
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per stage, after one overflow stage.
// The divisor is a configuration value the user must hold still while
// requests are in flight (not enforced); each stage reads it from the port.
module tsab_div_pipe #(
   parameter int NUM_W = 90,
   parameter int DEN_W = 72,
   parameter int QUO_W = 36
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0] in_den,
   output logic             out_valid,
   output logic [QUO_W-1:0] out_quo,
   output logic             out_ovf
);

   localparam int WORK_W = DEN_W + QUO_W;

   logic              valid_ff [QUO_W+1];
   logic [WORK_W-1:0] rem_ff   [QUO_W+1];
   logic [QUO_W-1:0]  quo_ff   [QUO_W+1];
   logic              ovf_ff   [QUO_W+1];
   logic [WORK_W-1:0] num_ext;
   logic [WORK_W-1:0] den_ext;

   assign num_ext = WORK_W'(in_num);
   assign den_ext = WORK_W'(in_den);

   // The quotient does not fit when the numerator reaches the divisor
   // shifted past the top quotient bit.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
      end
      rem_ff[0] <= num_ext;
      quo_ff[0] <= '0;
      ovf_ff[0] <= num_ext >= (den_ext << QUO_W);
   end

   for (genvar s = 1; s <= QUO_W; s++) begin : g_step
      localparam int SHIFT = QUO_W - s;

      logic [WORK_W-1:0] den_sh;
      logic [WORK_W-1:0] rem_in;
      logic [QUO_W-1:0]  quo_in;

      // Subtract the shifted divisor where it fits.
      always_comb begin
         den_sh = den_ext << SHIFT;
         if (rem_ff[s-1] >= den_sh) begin
            rem_in = rem_ff[s-1] - den_sh;
            quo_in = {quo_ff[s-1][QUO_W-2:0], 1'b1};
         end else begin
            rem_in = rem_ff[s-1];
            quo_in = {quo_ff[s-1][QUO_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= valid_ff[s-1];
         end
         rem_ff[s] <= rem_in;
         quo_ff[s] <= quo_in;
         ovf_ff[s] <= ovf_ff[s-1];
      end
   end

   assign out_valid = valid_ff[QUO_W];
   assign out_quo   = quo_ff[QUO_W];
   assign out_ovf   = ovf_ff[QUO_W];

endmodule

[hdl/tsab_checker.sv]
`timescale 1ns / 1ps

module tsab_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic                                rsp_strobe,
   input logic signed [tsab_pkg::BETA_W-1:0]  rsp_beta_min,
   input logic [tsab_pkg::ALPHA_W-1:0]        rsp_alpha_min,
   input logic [tsab_pkg::ALPHA_W-1:0]        rsp_alpha_max,
   input logic                                rsp_beta_invalid
);

   // Every response answers a request taken a fixed time before.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, tsab_pkg::LATENCY))
      else $error("response without a matching request");

   // beta_min is never positive.
   a_beta_min_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_beta_min[tsab_pkg::BETA_W-1] || rsp_beta_min == '0))
      else $error("beta_min is positive");

   // The lower limit never exceeds the upper limit.
   a_alpha_order: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_alpha_min <= rsp_alpha_max)
      else $error("alpha_min above alpha_max");

   // A clamped radicand leaves both limits equal.
   a_invalid_equal: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_beta_invalid) |-> rsp_alpha_min == rsp_alpha_max)
      else $error("alpha limits differ for an invalid beta");

endmodule

bind thermal_scatter_alpha_beta_limits_top tsab_checker u_checker (.*);

[dv/thermal_scatter_alpha_beta_limits_checker.sv]
`timescale 1ns / 1ps

module thermal_scatter_alpha_beta_limits_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic                                   busy,
   input  logic [tsab_pkg::ENERGY_W-1:0]          req_energy,
   input  logic signed [tsab_pkg::BETA_W-1:0]     req_beta,
   input  logic                                   rsp_strobe,
   input  logic signed [tsab_pkg::BETA_W-1:0]     rsp_beta_min,
   input  logic [tsab_pkg::ALPHA_W-1:0]           rsp_alpha_min,
   input  logic [tsab_pkg::ALPHA_W-1:0]           rsp_alpha_max,
   input  logic                                   rsp_beta_invalid,
   input  logic                                   rsp_saturated,
   input  logic                                   csr_write,
   input  logic [tsab_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [tsab_pkg::CSR_DATA_W-1:0]        csr_wdata,
   output int                                     fail_count,
   output int                                     pending_count
);

   typedef struct packed {
      logic [tsab_pkg::BETA_W-1:0]  beta_min;
      logic [tsab_pkg::ALPHA_W-1:0] alpha_min;
      logic [tsab_pkg::ALPHA_W-1:0] alpha_max;
      logic                         beta_invalid;
      logic                         saturated;
   } limits_type;

   limits_type                     limits_queue[$];
   logic [tsab_pkg::ENERGY_W-1:0]  kt_ff;
   logic [tsab_pkg::WEIGHT_W-1:0]  weight_ff;

   // Integer square root, rounded down.
   function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
      logic [63:0] root;
      logic [63:0] trial;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= v)
            root = trial;
      end
      return root;
   endfunction

   // Alpha quotient floor(n * 2^26 / den), clipped to 36 bits.
   function automatic logic [tsab_pkg::ALPHA_W-1:0] alpha_quotient(
         input logic [63:0] n, input logic [127:0] den, inout logic sat);
      logic [127:0] num;
      logic [127:0] quo;
      num = {64'd0, n} << 26;
      quo = num / den;
      if (quo >= (128'd1 << tsab_pkg::ALPHA_W)) begin
         sat = 1'b1;
         return tsab_pkg::ALPHA_SAT;
      end
      return quo[tsab_pkg::ALPHA_W-1:0];
   endfunction

   // Work out the limits for one request under the current kT and A.
   function automatic limits_type predict_limits(input logic [tsab_pkg::ENERGY_W-1:0] e,
                                                 input logic [tsab_pkg::BETA_W-1:0] b);
      limits_type   res;
      logic         neg;
      logic [63:0]  bmag;
      logic [127:0] prod;
      logic [127:0] e_scaled;
      logic [63:0]  r;
      logic [63:0]  q;
      logic [63:0]  se;
      logic [63:0]  sr;
      logic [63:0]  diff;
      logic [63:0]  sum;
      logic         sat;
      sat  = 1'b0;
      res.beta_invalid = 1'b0;
      neg  = b[tsab_pkg::BETA_W-1];
      bmag = neg ? (64'h1_0000_0000 - {32'd0, b}) : {32'd0, b};

      if (kt_ff == 0) begin
         res.beta_min = tsab_pkg::BETA_MIN_SAT;
         sat = 1'b1;
      end else begin
         q = ({24'd0, e} << 16) / {24'd0, kt_ff};
         if (q > 64'h8000_0000) begin
            q = 64'h8000_0000;
            sat = 1'b1;
         end
         res.beta_min = 32'(64'h1_0000_0000 - q);
      end

      // Radicand, exact in units of 2^-16, then floored.
      prod     = {64'd0, bmag} * {88'd0, kt_ff};
      e_scaled = {88'd0, e} << 16;
      if (!neg) begin
         r = 64'((e_scaled + prod) >> 16);
      end else if (prod > e_scaled) begin
         res.beta_invalid = 1'b1;
         r = 0;
      end else begin
         r = 64'((e_scaled - prod) >> 16);
      end

      se   = floor_sqrt({24'd0, e} << 6);
      sr   = floor_sqrt(r << 6);
      diff = se > sr ? se - sr : sr - se;
      sum  = se + sr;

      if (kt_ff == 0 || weight_ff == 0) begin
         res.alpha_min = tsab_pkg::ALPHA_SAT;
         res.alpha_max = tsab_pkg::ALPHA_SAT;
         sat = 1'b1;
      end else begin
         res.alpha_min = alpha_quotient(diff * diff,
                                        {96'd0, weight_ff} * {88'd0, kt_ff}, sat);
         res.alpha_max = alpha_quotient(sum * sum,
                                        {96'd0, weight_ff} * {88'd0, kt_ff}, sat);
      end
      res.saturated = sat;
      return res;
   endfunction

   assign pending_count = limits_queue.size();

   // Track configuration, predict accepted requests and compare responses.
   always @(posedge clock) begin
      limits_type want;
      if (reset) begin
         kt_ff     <= tsab_pkg::TEMPERATURE_RESET;
         weight_ff <= tsab_pkg::WEIGHT_RESET;
         limits_queue.delete();
         fail_count <= 0;
      end else begin
         if (csr_write) begin
            if (csr_index == tsab_pkg::CSR_TEMPERATURE_ENERGY)
               kt_ff <= csr_wdata[tsab_pkg::ENERGY_W-1:0];
            else if (csr_index == tsab_pkg::CSR_WEIGHT_RATIO)
               weight_ff <= csr_wdata[tsab_pkg::WEIGHT_W-1:0];
         end
         if (start && !busy)
            limits_queue.push_back(predict_limits(req_energy, req_beta));
         if (rsp_strobe) begin
            if (limits_queue.size() == 0) begin
               $error("response with no request outstanding");
               fail_count <= fail_count + 1;
            end else begin
               want = limits_queue.pop_front();
               if (rsp_beta_min !== want.beta_min ||
                   rsp_alpha_min !== want.alpha_min ||
                   rsp_alpha_max !== want.alpha_max ||
                   rsp_beta_invalid !== want.beta_invalid ||
                   rsp_saturated !== want.saturated)
                  fail_count <= fail_count + 1;
               if (rsp_beta_min !== want.beta_min)
                  $error("beta_min expected %h actual %h", want.beta_min, rsp_beta_min);
               if (rsp_alpha_min !== want.alpha_min)
                  $error("alpha_min expected %h actual %h", want.alpha_min, rsp_alpha_min);
               if (rsp_alpha_max !== want.alpha_max)
                  $error("alpha_max expected %h actual %h", want.alpha_max, rsp_alpha_max);
               if (rsp_beta_invalid !== want.beta_invalid)
                  $error("beta_invalid expected %b actual %b",
                         want.beta_invalid, rsp_beta_invalid);
               if (rsp_saturated !== want.saturated)
                  $error("saturated expected %b actual %b", want.saturated, rsp_saturated);
            end
         end
      end
   end
endmodule

[dv/thermal_scatter_alpha_beta_limits_top_test.sv]
`timescale 1ns / 1ps

module thermal_scatter_alpha_beta_limits_top_test;

   localparam int CYCLE_LIMIT = 400000;

   logic                                  clock;
   logic                                  reset;
   logic                                  start;
   logic                                  busy;
   logic [tsab_pkg::ENERGY_W-1:0]         req_energy;
   logic signed [tsab_pkg::BETA_W-1:0]    req_beta;
   logic                                  rsp_strobe;
   logic signed [tsab_pkg::BETA_W-1:0]    rsp_beta_min;
   logic [tsab_pkg::ALPHA_W-1:0]          rsp_alpha_min;
   logic [tsab_pkg::ALPHA_W-1:0]          rsp_alpha_max;
   logic                                  rsp_beta_invalid;
   logic                                  rsp_saturated;
   logic                                  csr_write;
   logic [tsab_pkg::CSR_INDEX_W-1:0]      csr_index;
   logic [tsab_pkg::CSR_DATA_W-1:0]       csr_wdata;
   int                                    fail_count;
   int                                    pending_count;
   int                                    cycle_count;

   thermal_scatter_alpha_beta_limits_top u_dut (.*);

   thermal_scatter_alpha_beta_limits_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog on total run length.
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // Present one request and hold it until accepted, then, for a nonzero gap, idle.
   task automatic send_request(input logic [tsab_pkg::ENERGY_W-1:0] e,
                               input logic [tsab_pkg::BETA_W-1:0] b,
                               input int gap);
      start      <= 1'b1;
      req_energy <= e;
      req_beta   <= b;
      do @(posedge clock); while (busy);
      if (gap > 0) begin
         start      <= 1'b0;
         req_energy <= tsab_pkg::ENERGY_W'({$urandom, $urandom});
         req_beta   <= $urandom;
         repeat (gap) @(posedge clock);
      end
   endtask

   // One register write, after which the port goes idle.
   task automatic write_register(input tsab_pkg::csr_index_type idx,
                                 input logic [tsab_pkg::CSR_DATA_W-1:0] v);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   // Wait for all outstanding responses, then let the pipeline drain fully.
   task automatic drain_pipeline();
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (tsab_pkg::LATENCY + 5) @(posedge clock);
   endtask

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   // Energy spread over many magnitudes, with a few full-range values.
   function automatic logic [tsab_pkg::ENERGY_W-1:0] pick_energy();
      int sh;
      sh = $urandom_range(0, 40);
      if ($urandom_range(0, 9) == 0) return tsab_pkg::ENERGY_W'({$urandom, $urandom});
      return tsab_pkg::ENERGY_W'({$urandom, $urandom}) >> sh;
   endfunction

   function automatic logic [tsab_pkg::BETA_W-1:0] pick_beta(
         input logic [tsab_pkg::ENERGY_W-1:0] e, input logic [tsab_pkg::ENERGY_W-1:0] kt);
      logic [63:0] bm;
      int          roll;
      roll = $urandom_range(0, 9);
      // Near the beta_min boundary, where the radicand approaches zero.
      if (roll < 3 && kt != 0) begin
         bm = ({24'd0, e} << 16) / {24'd0, kt};
         if (bm > 64'h8000_0000) bm = 64'h8000_0000;
         return tsab_pkg::BETA_W'(64'd0 - bm + 64'($signed($urandom_range(0, 6)) - 3));
      end
      if (roll < 6) return tsab_pkg::BETA_W'($urandom) >> $urandom_range(0, 31);
      return $urandom;
   endfunction

   task automatic run_phase(input logic [tsab_pkg::ENERGY_W-1:0] kt,
                            input logic [tsab_pkg::WEIGHT_W-1:0] a,
                            input int count);
      logic [tsab_pkg::ENERGY_W-1:0] e;
      write_register(tsab_pkg::CSR_TEMPERATURE_ENERGY, tsab_pkg::CSR_DATA_W'(kt));
      write_register(tsab_pkg::CSR_WEIGHT_RATIO, tsab_pkg::CSR_DATA_W'(a));
      for (int i = 0; i < count; i++) begin
         e = pick_energy();
         send_request(e, pick_beta(e, kt), (i % 200 < 60) ? 0 : pick_gap());
      end
      drain_pipeline();
   endtask

   initial begin
      reset      = 1'b1;
      start      = 1'b0;
      req_energy = '0;
      req_beta   = '0;
      csr_write  = 1'b0;
      csr_index  = tsab_pkg::CSR_TEMPERATURE_ENERGY;
      csr_wdata  = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      while (busy) @(posedge clock);

      // Directed requests under the reset configuration.
      send_request('0, '0, 0);
      send_request('1, '0, 0);
      send_request('1, 32'h7FFF_FFFF, 0);
      send_request('1, 32'h8000_0000, 1);
      send_request(40'd27818, 32'hFFFF_0000, 0);
      send_request(40'd27818, 32'hFFFE_FFFF, 0);
      send_request(40'd27818, 32'hFFFF_0001, 2);
      send_request(40'd1000, 32'h0001_0000, 0);
      send_request('0, 32'h8000_0000, 0);
      send_request('0, 32'h0000_0001, 0);
      send_request(40'h55_5555_5555, 32'hAAAA_AAAA, 0);
      send_request(40'hAA_AAAA_AAAA, 32'h5555_5555, 0);
      drain_pipeline();

      // Zero kT and zero A.
      write_register(tsab_pkg::CSR_TEMPERATURE_ENERGY, '0);
      send_request(40'd5000, 32'h8000_0000, 0);
      send_request('1, 32'h7FFF_FFFF, 0);
      drain_pipeline();
      write_register(tsab_pkg::CSR_TEMPERATURE_ENERGY,
                     tsab_pkg::CSR_DATA_W'(tsab_pkg::TEMPERATURE_RESET));
      write_register(tsab_pkg::CSR_WEIGHT_RATIO, '0);
      send_request(40'd5000, 32'hFFFF_0000, 0);
      send_request('1, 32'h0001_0000, 0);
      drain_pipeline();

      // Random phases across register settings, extremes included.
      run_phase(40'd27818, 32'd65536, 350);
      run_phase(40'd1, 32'd1, 150);
      run_phase('1, 32'hFFFF_FFFF, 150);
      run_phase(40'd1, 32'hFFFF_FFFF, 100);
      run_phase('1, 32'd1, 100);
      for (int p = 0; p < 7; p++)
         run_phase(tsab_pkg::ENERGY_W'({$urandom, $urandom}) >> $urandom_range(0, 39),
                   $urandom >> $urandom_range(0, 31), 100);

      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule

[thermal_scatter_alpha_beta_limits_top.f]
hdl/tsab_pkg.sv
hdl/tsab_sqrt_pipe.sv
hdl/tsab_div_pipe.sv
hdl/thermal_scatter_alpha_beta_limits_top.sv
hdl/tsab_checker.sv
dv/thermal_scatter_alpha_beta_limits_checker.sv
dv/thermal_scatter_alpha_beta_limits_top_test.sv
